### hw/rtl/dqp_pkg.sv
// dqp_pkg: shared types and constants for the dns query parser
// parse phases, status codes, width constants, item structs
// no dependencies
package dqp_pkg;

    localparam int MAX_NAME_LEN = 255;
    localparam int HEADER_BYTES = 12;
    localparam int NAME_LEN_W   = $clog2(MAX_NAME_LEN + 1);
    localparam int MAX_LABEL    = 63;

    localparam int OUT_FIELD_W = 8 + 16 + 16 + 1 + 3;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_LEN    = 3'd1;
    localparam logic [2:0] PH_LABEL  = 3'd2;
    localparam logic [2:0] PH_TYPE   = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_RESPONSE = 3'd1;
    localparam logic [2:0] ST_COUNT    = 3'd2;
    localparam logic [2:0] ST_CLASS    = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;
    localparam logic [2:0] ST_LONG     = 3'd5;

    localparam logic ITEM_CHAR    = 1'b0;
    localparam logic ITEM_SUMMARY = 1'b1;

    localparam logic [7:0] DOT_CHAR = 8'h2e;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } dqp_in_t;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  name_char;
        logic [15:0] query_id;
        logic [15:0] query_type;
        logic        recursion_wanted;
        logic [2:0]  status;
    } dqp_result_t;

endpackage

### hw/rtl/dqp_in_reg.sv
// dqp_in_reg: input register for the packet byte stream
// depends on dqp_pkg
module dqp_in_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,  // data_byte
    input  logic             s_axis_tlast,
    input  logic             take,
    output logic             in_valid,
    output dqp_pkg::dqp_in_t in_item
);
    import dqp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    dqp_in_t item_reg;

    assign s_axis_tready = !valid_reg || take;
    assign in_valid      = valid_reg;
    assign in_item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg.data_byte <= s_axis_tdata;
            item_reg.last_byte <= s_axis_tlast;
        end
    end

endmodule

### hw/rtl/dqp_parse.sv
// dqp_parse: per-byte parse state and result logic
// header fields, label to dotted text, type and class, summary status
// depends on dqp_pkg
module dqp_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  dqp_pkg::dqp_in_t     in_item,
    output logic                 res_valid,
    output dqp_pkg::dqp_result_t res
);
    import dqp_pkg::*;

    logic [2:0]            phase_reg, phase_next;
    logic [3:0]            pos_reg, pos_next;
    logic [5:0]            label_rem_reg, label_rem_next;
    logic                  first_label_reg, first_label_next;
    logic [NAME_LEN_W-1:0] name_len_reg, name_len_next;
    logic [7:0]            class_hi_reg, class_hi_next;
    logic [15:0]           id_reg, id_next;
    logic [15:0]           flags_reg, flags_next;
    logic [15:0]           cnt_type_reg, cnt_type_next;

    logic       sum;
    logic       chr;
    logic [2:0] status;
    logic [15:0] qtype;
    logic [7:0] c;
    logic [7:0] b;
    logic       name_full;

    assign b         = in_item.data_byte;
    assign name_full = name_len_reg >= NAME_LEN_W'(MAX_NAME_LEN);

    always_comb
    begin
        phase_next       = phase_reg;
        pos_next         = pos_reg;
        label_rem_next   = label_rem_reg;
        first_label_next = first_label_reg;
        name_len_next    = name_len_reg;
        class_hi_next    = class_hi_reg;
        id_next          = id_reg;
        flags_next       = flags_reg;
        cnt_type_next    = cnt_type_reg;
        sum    = 1'b0;
        chr    = 1'b0;
        status = ST_OK;
        qtype  = 16'd0;
        c      = 8'd0;

        case (phase_reg)
            PH_HEADER:
            begin
                if (pos_reg < 4'd2)
                begin
                    id_next = {id_reg[7:0], b};
                end
                else if (pos_reg < 4'd4)
                begin
                    flags_next = {flags_reg[7:0], b};
                end
                else if (pos_reg < 4'd6)
                begin
                    cnt_type_next = {cnt_type_reg[7:0], b};
                end
                if (pos_reg == 4'd3 && flags_next[15])
                begin
                    sum    = 1'b1;
                    status = ST_RESPONSE;
                end
                else if (pos_reg == 4'd5 && cnt_type_next != 16'd1)
                begin
                    sum    = 1'b1;
                    status = ST_COUNT;
                end
                pos_next = pos_reg + 4'd1;
                if (pos_next >= 4'(HEADER_BYTES))
                begin
                    phase_next = PH_LEN;
                    pos_next   = 4'd0;
                end
            end
            PH_LEN:
            begin
                if (b == 8'd0)
                begin
                    phase_next    = PH_TYPE;
                    pos_next      = 4'd0;
                    cnt_type_next = 16'd0;
                end
                else if (b > 8'(MAX_LABEL))
                begin
                    sum    = 1'b1;
                    status = ST_LONG;
                end
                else
                begin
                    label_rem_next = b[5:0];
                    if (!first_label_reg)
                    begin
                        if (name_full)
                        begin
                            sum    = 1'b1;
                            status = ST_LONG;
                        end
                        else
                        begin
                            chr           = 1'b1;
                            c             = DOT_CHAR;
                            name_len_next = name_len_reg + 1'b1;
                        end
                    end
                    first_label_next = 1'b0;
                    phase_next       = PH_LABEL;
                end
            end
            PH_LABEL:
            begin
                if (name_full)
                begin
                    sum    = 1'b1;
                    status = ST_LONG;
                end
                else
                begin
                    chr            = 1'b1;
                    c              = b;
                    name_len_next  = name_len_reg + 1'b1;
                    label_rem_next = label_rem_reg - 6'd1;
                    if (label_rem_next == 6'd0)
                    begin
                        phase_next = PH_LEN;
                    end
                end
            end
            PH_TYPE:
            begin
                if (pos_reg < 4'd2)
                begin
                    cnt_type_next = {cnt_type_reg[7:0], b};
                end
                else if (pos_reg == 4'd2)
                begin
                    class_hi_next = b;
                end
                else
                begin
                    sum    = 1'b1;
                    status = ({class_hi_reg, b} == 16'd1) ? ST_OK : ST_CLASS;
                    qtype  = cnt_type_reg;
                end
                pos_next = pos_reg + 4'd1;
            end
            default:
            begin
            end
        endcase

        // packet ends before the summary
        if (in_item.last_byte && phase_reg != PH_DONE && !sum)
        begin
            sum    = 1'b1;
            chr    = 1'b0;
            status = ST_TRUNC;
            qtype  = 16'd0;
        end

        if (sum)
        begin
            phase_next = PH_DONE;
        end

        res = '0;
        if (sum)
        begin
            res.item_kind        = ITEM_SUMMARY;
            res.query_id         = id_next;
            res.query_type       = qtype;
            res.recursion_wanted = flags_next[8];
            res.status           = status;
        end
        else
        begin
            res.item_kind = ITEM_CHAR;
            res.name_char = c;
        end
        res_valid = en && (sum || chr);

        if (in_item.last_byte)
        begin
            phase_next       = PH_HEADER;
            pos_next         = 4'd0;
            label_rem_next   = 6'd0;
            first_label_next = 1'b1;
            name_len_next    = '0;
            class_hi_next    = 8'd0;
            id_next          = 16'd0;
            flags_next       = 16'd0;
            cnt_type_next    = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEADER;
            pos_reg         <= 4'd0;
            label_rem_reg   <= 6'd0;
            first_label_reg <= 1'b1;
            name_len_reg    <= '0;
            class_hi_reg    <= 8'd0;
            id_reg          <= 16'd0;
            flags_reg       <= 16'd0;
            cnt_type_reg    <= 16'd0;
        end
        else if (en)
        begin
            phase_reg       <= phase_next;
            pos_reg         <= pos_next;
            label_rem_reg   <= label_rem_next;
            first_label_reg <= first_label_next;
            name_len_reg    <= name_len_next;
            class_hi_reg    <= class_hi_next;
            id_reg          <= id_next;
            flags_reg       <= flags_next;
            cnt_type_reg    <= cnt_type_next;
        end
    end

endmodule

### hw/rtl/dqp_out_reg.sv
// dqp_out_reg: result register driving the output stream
// depends on dqp_pkg
module dqp_out_reg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  dqp_pkg::dqp_result_t          res,
    output logic                          can_take,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // name_char, query_id, query_type, recursion_wanted, status, zero pad
    output logic [dqp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tuser  // item_kind
);
    import dqp_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    dqp_result_t res_reg;

    assign can_take      = !valid_reg || m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = res_reg.item_kind;
    assign m_axis_tdata  = OUT_TDATA_W'({res_reg.status, res_reg.recursion_wanted,
                                         res_reg.query_type, res_reg.query_id,
                                         res_reg.name_char});

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

### hw/rtl/dns_query_parser.sv
// dns_query_parser: top level, input register, parser, result register
// depends on dqp_pkg, dqp_in_reg, dqp_parse, dqp_out_reg
//
// channel   dir  tdata                                        tuser      tlast
// s_axis    in   data_byte                                    -          last_byte
// m_axis    out  name_char query_id query_type rd status      item_kind  -
//
// one packet byte per cycle sustained while m_axis_tready is high; input register
// then result register, the parse logic updates its state once per byte
// reset clears both valid flags and the parse state to the header phase
// a stalled result holds in the result register while the input register
// still takes one byte; s_axis_tready drops only when both are full
module dns_query_parser (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // data_byte
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // name_char, query_id, query_type, recursion_wanted, status, zero pad
    output logic [dqp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tuser   // item_kind
);
    import dqp_pkg::*;

    logic        in_valid;
    dqp_in_t     in_item;
    logic        can_take;
    logic        take;
    logic        res_valid;
    dqp_result_t res;

    assign take = in_valid && can_take;

    dqp_in_reg u_in_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .take          (take),
        .in_valid      (in_valid),
        .in_item       (in_item)
    );

    dqp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (take),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res       (res)
    );

    dqp_out_reg u_out_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (res_valid),
        .res           (res),
        .can_take      (can_take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

### hw/rtl/dqp_checker.sv
// dqp_checker: port-level assertions for dns_query_parser, with bind
// depends on dqp_pkg
module dqp_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [dqp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser
);
    import dqp_pkg::*;

    logic [2:0]  out_status;
    logic [15:0] out_type;

    assign out_status = m_axis_tdata[43:41];
    assign out_type   = m_axis_tdata[39:24];

    // stalled transfer holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output changed");

    a_char_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ITEM_CHAR |->
            m_axis_tdata[OUT_TDATA_W-1:8] == '0)
        else $error("name character item carries summary fields");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ITEM_SUMMARY |->
            out_status <= ST_LONG && m_axis_tdata[7:0] == 8'd0)
        else $error("bad summary status or nonzero char");

    a_type_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ITEM_SUMMARY &&
            out_status != ST_OK && out_status != ST_CLASS |-> out_type == 16'd0)
        else $error("query type given on error summary");

    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind dns_query_parser dqp_checker u_dqp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### bench/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for dns_query_parser, byte stream in, char/summary items out
// predicts every result from its own parser state and checks it in order on m_axis
// depends on dqp_pkg and dns_query_parser
module tb_top;
    import dqp_pkg::*;

    localparam int HANG_LIMIT = 3000;
    localparam int LONG_HOLD  = 80;
    localparam int PHASE_BYTES = 270;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_data = 8'h00;
    logic                   s_last = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_data;
    logic                   m_user;

    dqp_in_t     tx_bytes[$];
    logic [7:0]  pkt_bytes[$];
    dqp_result_t expected_items[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int total_queued = 0;
    int results_seen = 0;
    int mismatch_count = 0;
    int hang_count = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    // predicted parser state
    logic [2:0]  parse_ph;
    logic [3:0]  hdr_pos;
    logic [5:0]  label_left;
    logic        first_label;
    logic [9:0]  name_len;
    logic [15:0] hdr_id;
    logic [15:0] hdr_flags;
    logic [15:0] hdr_word;

    dns_query_parser u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tlast  (s_last),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic restart_query();
        parse_ph    = PH_HEADER;
        hdr_pos     = '0;
        label_left  = '0;
        first_label = 1'b1;
        name_len    = '0;
        hdr_id      = '0;
        hdr_flags   = '0;
        hdr_word    = '0;
    endtask

    task automatic parse_query_byte(input logic [7:0] b, input logic last);
        logic        was_done;
        logic        give_sum;
        logic        give_chr;
        logic [2:0]  st;
        logic [15:0] qtype;
        logic [7:0]  ch;
        logic [15:0] qclass;
        dqp_result_t r;
        was_done = (parse_ph == PH_DONE);
        give_sum = 1'b0;
        give_chr = 1'b0;
        st       = ST_OK;
        qtype    = '0;
        ch       = '0;
        case (parse_ph)
            PH_HEADER:
            begin
                if (hdr_pos < 2)
                    hdr_id = {hdr_id[7:0], b};
                else if (hdr_pos < 4)
                    hdr_flags = {hdr_flags[7:0], b};
                else if (hdr_pos < 6)
                    hdr_word = {hdr_word[7:0], b};
                if (hdr_pos == 3 && hdr_flags[15])
                begin
                    give_sum = 1'b1;
                    st = ST_RESPONSE;
                end
                else if (hdr_pos == 5 && hdr_word != 16'd1)
                begin
                    give_sum = 1'b1;
                    st = ST_COUNT;
                end
                hdr_pos = hdr_pos + 1'b1;
                if (hdr_pos >= HEADER_BYTES)
                begin
                    parse_ph = PH_LEN;
                    hdr_pos = '0;
                end
            end
            PH_LEN:
            begin
                if (b == 8'd0)
                begin
                    parse_ph = PH_TYPE;
                    hdr_pos = '0;
                    hdr_word = '0;
                end
                else if (b > MAX_LABEL)
                begin
                    give_sum = 1'b1;
                    st = ST_LONG;
                end
                else
                begin
                    label_left = b[5:0];
                    if (!first_label)
                    begin
                        if (name_len >= MAX_NAME_LEN)
                        begin
                            give_sum = 1'b1;
                            st = ST_LONG;
                        end
                        else
                        begin
                            give_chr = 1'b1;
                            ch = DOT_CHAR;
                            name_len = name_len + 1'b1;
                        end
                    end
                    first_label = 1'b0;
                    parse_ph = PH_LABEL;
                end
            end
            PH_LABEL:
            begin
                if (name_len >= MAX_NAME_LEN)
                begin
                    give_sum = 1'b1;
                    st = ST_LONG;
                end
                else
                begin
                    give_chr = 1'b1;
                    ch = b;
                    name_len = name_len + 1'b1;
                    label_left = label_left - 1'b1;
                    if (label_left == 0)
                        parse_ph = PH_LEN;
                end
            end
            PH_TYPE:
            begin
                if (hdr_pos < 2)
                    hdr_word = {hdr_word[7:0], b};
                else if (hdr_pos == 2)
                    name_len = {2'b00, b};
                else
                begin
                    // class high byte was parked in the name length
                    qclass = {name_len[7:0], b};
                    give_sum = 1'b1;
                    st = (qclass == 16'd1) ? ST_OK : ST_CLASS;
                    qtype = hdr_word;
                end
                hdr_pos = hdr_pos + 1'b1;
            end
            default:
            begin
            end
        endcase

        if (last && !was_done && !give_sum)
        begin
            give_sum = 1'b1;
            give_chr = 1'b0;
            st = ST_TRUNC;
            qtype = '0;
        end

        if (give_sum)
        begin
            r = '{item_kind: ITEM_SUMMARY, name_char: 8'h00, query_id: hdr_id,
                  query_type: qtype, recursion_wanted: hdr_flags[8], status: st};
            expected_items.push_back(r);
            parse_ph = PH_DONE;
        end
        else if (give_chr)
        begin
            r = '{item_kind: ITEM_CHAR, name_char: ch, query_id: 16'h0000,
                  query_type: 16'h0000, recursion_wanted: 1'b0, status: ST_OK};
            expected_items.push_back(r);
        end

        if (last)
            restart_query();
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("%0t: %s: got %0h expected %0h", $time, what, got, want);
    endtask

    task automatic check_result(input logic kind, input logic [OUT_TDATA_W-1:0] d);
        dqp_result_t want;
        if (expected_items.size() == 0)
        begin
            report_mismatch("unexpected result", int'({kind, d[7:0]}), 0);
        end
        else
        begin
            want = expected_items.pop_front();
            if (kind !== want.item_kind)
                report_mismatch("item_kind", int'(kind), int'(want.item_kind));
            if (d[7:0] !== want.name_char)
                report_mismatch("name_char", int'(d[7:0]), int'(want.name_char));
            if (d[23:8] !== want.query_id)
                report_mismatch("query_id", int'(d[23:8]), int'(want.query_id));
            if (d[39:24] !== want.query_type)
                report_mismatch("query_type", int'(d[39:24]), int'(want.query_type));
            if (d[40] !== want.recursion_wanted)
                report_mismatch("recursion_wanted", int'(d[40]),
                                int'(want.recursion_wanted));
            if (d[43:41] !== want.status)
                report_mismatch("status", int'(d[43:41]), int'(want.status));
        end
    endtask

    // moves the assembled packet to the send queue, keeping only its first bytes if asked
    task automatic send_packet(input int keep);
        if (keep <= 0 || keep > pkt_bytes.size())
            keep = pkt_bytes.size();
        for (int i = 0; i < keep; i++)
            tx_bytes.push_back('{data_byte: pkt_bytes[i], last_byte: (i == keep - 1)});
        total_queued += keep;
        pkt_bytes.delete();
    endtask

    task automatic put_header(input logic [15:0] id, input logic [15:0] flags,
                              input logic [15:0] count);
        pkt_bytes.push_back(id[15:8]);
        pkt_bytes.push_back(id[7:0]);
        pkt_bytes.push_back(flags[15:8]);
        pkt_bytes.push_back(flags[7:0]);
        pkt_bytes.push_back(count[15:8]);
        pkt_bytes.push_back(count[7:0]);
        for (int i = 0; i < 6; i++)
            pkt_bytes.push_back(8'($urandom));
    endtask

    task automatic put_label(input int len);
        pkt_bytes.push_back(8'(len));
        for (int i = 0; i < len; i++)
            pkt_bytes.push_back($urandom_range(1) ? 8'($urandom) : 8'($urandom_range(97, 122)));
    endtask

    task automatic make_query();
        int          kind;
        int          n_lab;
        logic [15:0] flags;
        logic [15:0] count;
        logic [15:0] qclass;
        kind  = $urandom_range(99);
        flags = 16'($urandom);
        flags[15] = (kind < 6);
        count = 16'd1;
        if (kind >= 6 && kind < 12)
        begin
            count = $urandom_range(1) ? 16'($urandom_range(3)) : 16'($urandom);
            if (count == 16'd1)
                count = 16'd2;
        end
        if (kind >= 94)
        begin
            // raw noise
            n_lab = $urandom_range(1, 30);
            for (int i = 0; i < n_lab; i++)
                pkt_bytes.push_back(8'($urandom));
            send_packet(0);
            return;
        end
        put_header(16'($urandom), flags, count);
        if (kind >= 90)
        begin
            // four full labels hit the name limit exactly, a fifth goes over
            for (int i = 0; i < 4; i++)
                put_label(MAX_LABEL);
            if ($urandom_range(1))
                put_label($urandom_range(1, MAX_LABEL));
        end
        else
        begin
            n_lab = $urandom_range(4);
            for (int i = 0; i < n_lab; i++)
                put_label($urandom_range(9) == 0 ? $urandom_range(1, MAX_LABEL)
                                                 : $urandom_range(1, 8));
        end
        if (kind >= 12 && kind < 18)
        begin
            // length byte over the label limit, compression pointers included
            pkt_bytes.push_back(8'($urandom_range(MAX_LABEL + 1, 255)));
            for (int i = 0; i < 5; i++)
                pkt_bytes.push_back(8'($urandom));
        end
        pkt_bytes.push_back(8'h00);
        flags = $urandom_range(1) ? 16'($urandom_range(1, 28)) : 16'($urandom);
        pkt_bytes.push_back(flags[15:8]);
        pkt_bytes.push_back(flags[7:0]);
        qclass = 16'd1;
        if (kind >= 18 && kind < 30)
        begin
            case ($urandom_range(3))
                0: qclass = 16'h0101;
                1: qclass = 16'h0000;
                2: qclass = 16'hFFFF;
                default: qclass = 16'($urandom);
            endcase
            if (qclass == 16'd1)
                qclass = 16'h0003;
        end
        pkt_bytes.push_back(qclass[15:8]);
        pkt_bytes.push_back(qclass[7:0]);
        n_lab = $urandom_range(3);
        for (int i = 0; i < n_lab; i++)
            pkt_bytes.push_back(8'($urandom));
        if (kind >= 30 && kind < 42)
            send_packet($urandom_range(1, pkt_bytes.size()));
        else
            send_packet(0);
    endtask

    task automatic wait_drained();
        while (tx_bytes.size() != 0 || s_valid || expected_items.size() != 0)
            @(posedge clk);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        dqp_in_t next_in;
        if (!rst_n)
        begin
            s_valid <= 1'b0;
            s_data  <= 8'h00;
            s_last  <= 1'b0;
        end
        else
        begin
            if (s_valid && s_ready)
                parse_query_byte(s_data, s_last);
            if (!s_valid || s_ready)
            begin
                if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_in = tx_bytes.pop_front();
                    s_valid <= 1'b1;
                    s_data  <= next_in.data_byte;
                    s_last  <= next_in.last_byte;
                end
                else
                begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver, with one long hold-off to back the block up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_ready   <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && results_seen >= 30)
        begin
            m_ready   <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end
        else
        begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_valid && m_ready)
        begin
            check_result(m_user, m_data);
            results_seen <= results_seen + 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                hang_count <= 0;
            else
                hang_count <= hang_count + 1;
            if (hang_count >= HANG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin : stim_proc
        int phase_start;
        restart_query();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // lone truncated byte
        pkt_bytes.push_back(8'hFF);
        send_packet(0);
        // response with recursion bit, ends on the flags byte
        put_header(16'hFFFF, 16'h8100, 16'd1);
        send_packet(4);
        // question count of two
        put_header(16'h0000, 16'h0000, 16'd2);
        send_packet(6);
        // root name, type 255, class IN
        put_header(16'h1234, 16'h0100, 16'd1);
        pkt_bytes.push_back(8'h00);
        pkt_bytes.push_back(8'h00);
        pkt_bytes.push_back(8'hFF);
        pkt_bytes.push_back(8'h00);
        pkt_bytes.push_back(8'h01);
        send_packet(0);

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 53;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 53;
                end
                default:
                begin
                    send_idle_pct = 36;
                    recv_stall_pct = 36;
                end
            endcase
            phase_start = total_queued;
            while (total_queued - phase_start < PHASE_BYTES)
                make_query();
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
